/* sv/rcps_pkg.sv */
// shared constants, register codes and types for the rc pwm capture scaler
`default_nettype none

package rcps_pkg;

   localparam int CAL_BITS         = 17;
   localparam int SPAN_BITS        = 16;
   localparam int TICK_BITS        = 32;
   localparam int VAL_BITS         = 16;
   localparam int CSR_IDX_BITS     = 3;
   localparam int CSR_DATA_BITS    = 32;
   localparam int DEF_NUM_CHANNELS = 2;
   localparam int DEF_STAMP_BITS   = 16;

   localparam logic [CSR_IDX_BITS-1:0] REG_THR_MIN = CSR_IDX_BITS'(0);
   localparam logic [CSR_IDX_BITS-1:0] REG_THR_MAX = CSR_IDX_BITS'(1);
   localparam logic [CSR_IDX_BITS-1:0] REG_STE_MIN = CSR_IDX_BITS'(2);
   localparam logic [CSR_IDX_BITS-1:0] REG_STE_MAX = CSR_IDX_BITS'(3);
   localparam logic [CSR_IDX_BITS-1:0] REG_SPAN    = CSR_IDX_BITS'(4);
   localparam logic [CSR_IDX_BITS-1:0] REG_TIMEOUT = CSR_IDX_BITS'(5);

   localparam logic [CAL_BITS-1:0]  RST_THR_MIN = CAL_BITS'(858);
   localparam logic [CAL_BITS-1:0]  RST_THR_MAX = CAL_BITS'(2062);
   localparam logic [CAL_BITS-1:0]  RST_STE_MIN = CAL_BITS'(948);
   localparam logic [CAL_BITS-1:0]  RST_STE_MAX = CAL_BITS'(2152);
   localparam logic [SPAN_BITS-1:0] RST_SPAN    = SPAN_BITS'(1000);
   localparam logic [TICK_BITS-1:0] RST_TIMEOUT = TICK_BITS'(100);

   localparam logic [VAL_BITS-1:0] SAT_VALUE = '1;
   localparam logic [VAL_BITS-1:0] IDLE_LOW  = VAL_BITS'(495);
   localparam logic [VAL_BITS-1:0] IDLE_HIGH = VAL_BITS'(505);

   localparam logic OP_EDGE  = 1'b0;
   localparam logic OP_READ  = 1'b1;
   localparam logic CHAN_THR = 1'b0;
   localparam logic CHAN_STE = 1'b1;

   typedef struct packed {
      logic [CAL_BITS-1:0]  lo;
      logic [CAL_BITS-1:0]  hi;
      logic [SPAN_BITS-1:0] span;
      logic [TICK_BITS-1:0] timeout;
   } cal_type;

   typedef struct packed {
      logic                done;
      logic [VAL_BITS-1:0] value;
   } scale_rsp_type;

endpackage

`default_nettype wire

/* sv/rcps_capture.sv */
// per-channel edge phase machines with stored pulse widths and pulse ticks
`default_nettype none

module rcps_capture
   import rcps_pkg::*;
#(
   parameter int NUM_CHANNELS = DEF_NUM_CHANNELS,
   parameter int STAMP_BITS   = DEF_STAMP_BITS,
   localparam int WIDTH_BITS  = STAMP_BITS + 1,
   localparam int CH_BITS     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  ev_valid,
   input  logic                  ev_chan,
   input  logic                  ev_level,
   input  logic [STAMP_BITS-1:0] ev_stamp,
   input  logic [TICK_BITS-1:0]  ev_tick,
   input  logic                  rd_chan,
   output logic [WIDTH_BITS-1:0] rd_width,
   output logic [TICK_BITS-1:0]  rd_tick
);

   logic [NUM_CHANNELS-1:0] armed_ff, armed_in;
   logic [STAMP_BITS-1:0]   rise_ff  [NUM_CHANNELS];
   logic [STAMP_BITS-1:0]   rise_in  [NUM_CHANNELS];
   logic [WIDTH_BITS-1:0]   width_ff [NUM_CHANNELS];
   logic [WIDTH_BITS-1:0]   width_in [NUM_CHANNELS];
   logic [TICK_BITS-1:0]    tick_ff  [NUM_CHANNELS];
   logic [TICK_BITS-1:0]    tick_in  [NUM_CHANNELS];
   logic [CH_BITS-1:0]      ev_idx, rd_idx;

   assign ev_idx = CH_BITS'(ev_chan);
   assign rd_idx = CH_BITS'(rd_chan);

   always_comb begin
      armed_in = armed_ff;
      for (int k = 0; k < NUM_CHANNELS; k++) begin
         rise_in[k]  = rise_ff[k];
         width_in[k] = width_ff[k];
         tick_in[k]  = tick_ff[k];
         if (ev_valid && (ev_idx == CH_BITS'(k))) begin
            priority if (ev_level && !armed_ff[k]) begin
               rise_in[k]  = ev_stamp;
               armed_in[k] = 1'b1;
            end else if (!ev_level && armed_ff[k]) begin
               width_in[k] = {ev_stamp - rise_ff[k], 1'b0};
               tick_in[k]  = ev_tick;
               armed_in[k] = 1'b0;
            end else begin
               armed_in[k] = 1'b0;
            end
         end
      end
   end

   // channels that do not exist read as no pulse
   always_comb begin
      rd_width = '0;
      rd_tick  = '0;
      for (int k = 0; k < NUM_CHANNELS; k++) begin
         if (rd_idx == CH_BITS'(k)) begin
            rd_width = width_ff[k];
            rd_tick  = tick_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff <= '0;
         for (int k = 0; k < NUM_CHANNELS; k++) begin
            rise_ff[k]  <= '0;
            width_ff[k] <= '0;
            tick_ff[k]  <= '0;
         end
      end else begin
         armed_ff <= armed_in;
         for (int k = 0; k < NUM_CHANNELS; k++) begin
            rise_ff[k]  <= rise_in[k];
            width_ff[k] <= width_in[k];
            tick_ff[k]  <= tick_in[k];
         end
      end
   end

endmodule

`default_nettype wire

/* sv/rcps_scale.sv */
// shared scaling unit: validity checks, one multiply, then a bit-serial restoring divider
`default_nettype none

module rcps_scale
   import rcps_pkg::*;
#(
   parameter int STAMP_BITS  = DEF_STAMP_BITS,
   localparam int WIDTH_BITS = STAMP_BITS + 1,
   localparam int XW         = (WIDTH_BITS > CAL_BITS) ? WIDTH_BITS : CAL_BITS,
   localparam int PW         = XW + VAL_BITS,
   localparam int CNT_BITS   = $clog2(VAL_BITS)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  cal_type               cal,
   input  logic [WIDTH_BITS-1:0] width,
   input  logic [TICK_BITS-1:0]  tick,
   input  logic [TICK_BITS-1:0]  now,
   output scale_rsp_type         rsp
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MUL  = 3'd1;
   localparam logic [2:0] S_CHK  = 3'd2;
   localparam logic [2:0] S_DIV  = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic                zero_ff, zero_in;
   logic [XW-1:0]       diff_ff, diff_in;
   logic [CAL_BITS-1:0] div_ff, div_in;
   logic [PW-1:0]       prod_ff, prod_in;
   logic [CAL_BITS-1:0] rem_ff, rem_in;
   logic [VAL_BITS-1:0] lq_ff, lq_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [VAL_BITS-1:0] val_ff, val_in;

   logic [XW-1:0]         w_x, lo_x, hi_part;
   logic [TICK_BITS-1:0]  age;
   logic [CAL_BITS:0]     trial, div_x;
   logic                  take;

   assign w_x     = XW'(width);
   assign lo_x    = XW'(cal.lo);
   assign age     = now - tick;
   assign hi_part = prod_ff[PW-1:VAL_BITS];
   assign trial   = {rem_ff, lq_ff[VAL_BITS-1]};
   assign div_x   = {1'b0, div_ff};
   assign take    = (trial >= div_x);

   always_comb begin
      state_in = state_ff;
      zero_in  = zero_ff;
      diff_in  = diff_ff;
      div_in   = div_ff;
      prod_in  = prod_ff;
      rem_in   = rem_ff;
      lq_in    = lq_ff;
      cnt_in   = cnt_ff;
      val_in   = val_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               zero_in  = (width == '0) || (age > cal.timeout) ||
                          (cal.hi <= cal.lo) || (w_x < lo_x);
               diff_in  = w_x - lo_x;
               div_in   = cal.hi - cal.lo;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            prod_in  = PW'(diff_ff) * PW'(cal.span);
            state_in = S_CHK;
         end
         S_CHK: begin
            priority if (zero_ff) begin
               val_in   = '0;
               state_in = S_DONE;
            end else if (hi_part >= XW'(div_ff)) begin
               val_in   = SAT_VALUE;
               state_in = S_DONE;
            end else begin
               rem_in   = hi_part[CAL_BITS-1:0];
               lq_in    = prod_ff[VAL_BITS-1:0];
               cnt_in   = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            rem_in = take ? CAL_BITS'(trial - div_x) : trial[CAL_BITS-1:0];
            lq_in  = {lq_ff[VAL_BITS-2:0], take};
            cnt_in = cnt_ff + CNT_BITS'(1);
            if (cnt_ff == CNT_BITS'(VAL_BITS - 1)) begin
               val_in   = lq_in;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp.done  = (state_ff == S_DONE);
   assign rsp.value = val_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      zero_ff <= zero_in;
      diff_ff <= diff_in;
      div_ff  <= div_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
      lq_ff   <= lq_in;
      cnt_ff  <= cnt_in;
      val_ff  <= val_in;
   end

endmodule

`default_nettype wire

/* sv/rc_pwm_capture_scaler.sv */
// top level: rc pwm pulse capture with calibrated scaling of throttle and steering
// an edge word is taken and req_ready stays high
// a read word scales throttle, then steering, through the shared 16-step divider and then gives
// rsp_valid; a channel that reads zero or saturates skips the divider
// req_ready is low from a read until its result is loaded, so reads do not overlap
// synchronous reset clears the phase machines, widths, ticks and restores register defaults
`default_nettype none

module rc_pwm_capture_scaler
   import rcps_pkg::*;
#(
   parameter int NUM_CHANNELS = DEF_NUM_CHANNELS,
   parameter int STAMP_BITS   = DEF_STAMP_BITS,
   localparam int WIDTH_BITS  = STAMP_BITS + 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_op,
   input  logic                     req_chan,
   input  logic                     req_pin_level,
   input  logic [STAMP_BITS-1:0]    req_capture_stamp,
   input  logic [TICK_BITS-1:0]     req_now_tick,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [VAL_BITS-1:0]      rsp_throttle_value,
   output logic [VAL_BITS-1:0]      rsp_steering_value,
   output logic                     rsp_link_up,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_data
);

   localparam logic [2:0] T_IDLE     = 3'd0;
   localparam logic [2:0] T_THR_GO   = 3'd1;
   localparam logic [2:0] T_THR_WAIT = 3'd2;
   localparam logic [2:0] T_STE_GO   = 3'd3;
   localparam logic [2:0] T_STE_WAIT = 3'd4;
   localparam logic [2:0] T_OUT      = 3'd5;

   logic [2:0]           state_ff, state_in;
   logic [CAL_BITS-1:0]  thr_min_ff, thr_max_ff, ste_min_ff, ste_max_ff;
   logic [SPAN_BITS-1:0] span_ff;
   logic [TICK_BITS-1:0] timeout_ff;
   logic [TICK_BITS-1:0] now_ff, now_in;
   logic [VAL_BITS-1:0]  thr_ff, thr_in, ste_ff, ste_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [VAL_BITS-1:0]  rsp_thr_ff, rsp_thr_in, rsp_ste_ff, rsp_ste_in;
   logic                 rsp_link_ff, rsp_link_in;

   logic                  req_take, ev_valid, sel_chan, start;
   logic [WIDTH_BITS-1:0] sel_width;
   logic [TICK_BITS-1:0]  sel_tick;
   cal_type               cal;
   scale_rsp_type         scale_rsp;

   assign req_ready = (state_ff == T_IDLE);
   assign csr_ready = 1'b1;
   assign req_take  = req_valid && req_ready;
   assign ev_valid  = req_take && (req_op == OP_EDGE);
   assign sel_chan  = ((state_ff == T_STE_GO) || (state_ff == T_STE_WAIT)) ? CHAN_STE : CHAN_THR;
   assign start     = (state_ff == T_THR_GO) || (state_ff == T_STE_GO);

   assign cal.lo      = (sel_chan == CHAN_STE) ? ste_min_ff : thr_min_ff;
   assign cal.hi      = (sel_chan == CHAN_STE) ? ste_max_ff : thr_max_ff;
   assign cal.span    = span_ff;
   assign cal.timeout = timeout_ff;

   rcps_capture #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .STAMP_BITS   (STAMP_BITS)
   ) u_capture (
      .clock    (clock),
      .reset    (reset),
      .ev_valid (ev_valid),
      .ev_chan  (req_chan),
      .ev_level (req_pin_level),
      .ev_stamp (req_capture_stamp),
      .ev_tick  (req_now_tick),
      .rd_chan  (sel_chan),
      .rd_width (sel_width),
      .rd_tick  (sel_tick)
   );

   rcps_scale #(
      .STAMP_BITS (STAMP_BITS)
   ) u_scale (
      .clock (clock),
      .reset (reset),
      .start (start),
      .cal   (cal),
      .width (sel_width),
      .tick  (sel_tick),
      .now   (now_ff),
      .rsp   (scale_rsp)
   );

   always_comb begin
      state_in     = state_ff;
      now_in       = now_ff;
      thr_in       = thr_ff;
      ste_in       = ste_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_thr_in   = rsp_thr_ff;
      rsp_ste_in   = rsp_ste_ff;
      rsp_link_in  = rsp_link_ff;
      unique case (state_ff)
         T_IDLE: begin
            if (req_take && (req_op == OP_READ)) begin
               now_in   = req_now_tick;
               state_in = T_THR_GO;
            end
         end
         T_THR_GO: begin
            state_in = T_THR_WAIT;
         end
         T_THR_WAIT: begin
            if (scale_rsp.done) begin
               thr_in   = scale_rsp.value;
               state_in = T_STE_GO;
            end
         end
         T_STE_GO: begin
            state_in = T_STE_WAIT;
         end
         T_STE_WAIT: begin
            if (scale_rsp.done) begin
               ste_in   = scale_rsp.value;
               state_in = T_OUT;
            end
         end
         T_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_thr_in   = thr_ff;
               rsp_ste_in   = ste_ff;
               rsp_link_in  = !((ste_ff == '0) && (thr_ff > IDLE_LOW) && (thr_ff < IDLE_HIGH));
               state_in     = T_IDLE;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         rsp_valid_ff <= 1'b0;
         thr_min_ff   <= RST_THR_MIN;
         thr_max_ff   <= RST_THR_MAX;
         ste_min_ff   <= RST_STE_MIN;
         ste_max_ff   <= RST_STE_MAX;
         span_ff      <= RST_SPAN;
         timeout_ff   <= RST_TIMEOUT;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               REG_THR_MIN: thr_min_ff <= csr_data[CAL_BITS-1:0];
               REG_THR_MAX: thr_max_ff <= csr_data[CAL_BITS-1:0];
               REG_STE_MIN: ste_min_ff <= csr_data[CAL_BITS-1:0];
               REG_STE_MAX: ste_max_ff <= csr_data[CAL_BITS-1:0];
               REG_SPAN:    span_ff    <= csr_data[SPAN_BITS-1:0];
               REG_TIMEOUT: timeout_ff <= csr_data[TICK_BITS-1:0];
               default: begin
               end
            endcase
         end
      end
      now_ff     <= now_in;
      thr_ff     <= thr_in;
      ste_ff     <= ste_in;
      rsp_thr_ff <= rsp_thr_in;
      rsp_ste_ff <= rsp_ste_in;
      rsp_link_ff <= rsp_link_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_throttle_value = rsp_thr_ff;
   assign rsp_steering_value = rsp_ste_ff;
   assign rsp_link_up        = rsp_link_ff;

endmodule

`default_nettype wire

/* sv/rcps_checker.sv */
// port-level assertions for the rc pwm capture scaler and their bind
`default_nettype none

module rcps_checker
   import rcps_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     req_op,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [VAL_BITS-1:0]      rsp_throttle_value,
   input logic [VAL_BITS-1:0]      rsp_steering_value,
   input logic                     rsp_link_up
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_throttle_value) &&
      $stable(rsp_steering_value) && $stable(rsp_link_up))
      else $error("result word changed while stalled");

   // link flag follows the idle-throttle, zero-steering rule
   a_link: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_link_up ==
      !((rsp_steering_value == '0) && (rsp_throttle_value > IDLE_LOW) &&
        (rsp_throttle_value < IDLE_HIGH))))
      else $error("link flag inconsistent with values");

   // a read word makes the block busy
   a_read_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_op == OP_READ) |=> !req_ready)
      else $error("ready after read word");

   // an edge word leaves the block ready
   a_edge_fast: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_op == OP_EDGE) |=> req_ready)
      else $error("busy after edge word");

   // no result straight out of reset
   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind rc_pwm_capture_scaler rcps_checker u_rcps_checker (.*);

`default_nettype wire
